>>> rtl/fcs_pkg.sv
package fcs_pkg;

  localparam int unsigned MaxFrameBytesDef = 127;
  localparam int unsigned LenFieldMax      = 127;
  localparam int unsigned LenW             = 7;
  localparam int unsigned CountW           = 16;

  localparam logic [15:0]     CrcPolyRefl = 16'h8408;
  localparam logic [LenW-1:0] MinLenReset = 7'd11;
  localparam logic [1:0]      TypeMask    = 2'b11;

  typedef enum logic [1:0] {
    FS_ACCEPTED  = 2'd0,
    FS_TOO_SHORT = 2'd1,
    FS_CRC_ERROR = 2'd2
  } frame_status_e;

  // reflected crc-16, one byte lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = b[k] ^ c[0];
      c  = {1'b0, c[15:1]};
      if (fb) begin
        c = c ^ CrcPolyRefl;
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/fcs_rx_if.sv
interface fcs_rx_if
  import fcs_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> rtl/fcs_st_if.sv
interface fcs_st_if
  import fcs_pkg::*;
();
  logic              valid;
  logic              ready;
  frame_status_e     frame_status;
  logic              is_beacon;
  logic [LenW-1:0]   frame_length;
  logic [CountW-1:0] frames_received;
  logic [CountW-1:0] frames_bad;

  modport source (output valid, output frame_status, output is_beacon, output frame_length,
                  output frames_received, output frames_bad, input ready);
  modport sink (input valid, input frame_status, input is_beacon, input frame_length,
                input frames_received, input frames_bad, output ready);
endinterface

>>> rtl/frame_fcs_checker.sv
// frame_fcs_checker: checks the crc-16 fcs of received frames
// rx_i carries one frame byte per word, fcs bytes included, with last_byte
// set on the final byte. st_o gives one status word per frame, on its last
// byte: accepted, too short (not counted) or crc error, plus beacon flag,
// saturated length and the received and bad frame counters.
// cfg_we_i / cfg_wdata_i write the minimum frame length; the user must write
// it only while idle, the block does not enforce this. a byte is registered
// in the input register when it is accepted and processed from there, where
// crc, count and counters update and the status word is loaded into the
// output register. one byte per cycle is sustained unless a last byte waits
// on a stalled st_o; the crc update of one byte is a single combinational
// step between the input and output registers. if st_o stalls, bytes that
// are not last keep flowing; a last byte waits in the input register until
// the output register frees, and rx_i.ready drops. reset clears crc, count,
// counters and both valid flags and sets the minimum length to 11.
module frame_fcs_checker
  import fcs_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = MaxFrameBytesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  fcs_rx_if.sink          rx_i,
  fcs_st_if.source        st_o,
  input  logic            cfg_we_i,
  input  logic [LenW-1:0] cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned CmpW = (CntW > LenW) ? CntW : LenW;
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_FRAME_BYTES);

  logic [LenW-1:0]   min_len_q;
  logic              s1_valid_q;
  logic [7:0]        s1_byte_q;
  logic              s1_last_q;
  logic [15:0]       crc_q, crc_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [1:0]        tb_q, tb_d;
  logic [CountW-1:0] rcv_q, rcv_d;
  logic [CountW-1:0] bad_q, bad_d;
  logic              out_valid_q;
  frame_status_e     status_q, status_d;
  logic              beacon_q, beacon_d;
  logic [LenW-1:0]   len_q, len_d;

  logic              out_free;
  logic              s1_adv;
  logic              rx_fire;
  logic [15:0]       crc_n;
  logic [CntW-1:0]   cnt_n;
  logic [CmpW-1:0]   cnt_ext;

  assign out_free  = !out_valid_q || st_o.ready;
  assign s1_adv    = s1_valid_q && (!s1_last_q || out_free);
  assign rx_i.ready = !s1_valid_q || s1_adv;
  assign rx_fire   = rx_i.valid && rx_i.ready;

  always_comb begin
    crc_n   = crc_byte(crc_q, s1_byte_q);
    cnt_n   = (cnt_q < CntMax) ? cnt_q + CntW'(1) : cnt_q;
    cnt_ext = CmpW'(cnt_n);
    tb_d    = (cnt_q == '0) ? (s1_byte_q[1:0] & TypeMask) : tb_q;
    crc_d   = crc_n;
    cnt_d   = cnt_n;
    rcv_d   = rcv_q;
    bad_d   = bad_q;
    beacon_d = 1'b0;
    status_d = FS_ACCEPTED;
    len_d   = (cnt_ext > CmpW'(LenFieldMax)) ? LenW'(LenFieldMax) : cnt_ext[LenW-1:0];
    if (s1_last_q) begin
      crc_d = '0;
      cnt_d = '0;
      if (cnt_ext < CmpW'(min_len_q)) begin
        status_d = FS_TOO_SHORT;
      end else begin
        rcv_d = rcv_q + CountW'(1);
        if (crc_n != '0) begin
          bad_d    = bad_q + CountW'(1);
          status_d = FS_CRC_ERROR;
        end else begin
          beacon_d = (tb_d == 2'b00);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q   <= MinLenReset;
      s1_valid_q  <= 1'b0;
      crc_q       <= '0;
      cnt_q       <= '0;
      tb_q        <= '0;
      rcv_q       <= '0;
      bad_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        min_len_q <= cfg_wdata_i;
      end
      if (rx_i.ready) begin
        s1_valid_q <= rx_i.valid;
      end
      if (s1_adv) begin
        crc_q <= crc_d;
        cnt_q <= cnt_d;
        tb_q  <= tb_d;
        rcv_q <= rcv_d;
        bad_q <= bad_d;
      end
      if (s1_adv && s1_last_q) begin
        out_valid_q <= 1'b1;
      end else if (st_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_fire) begin
      s1_byte_q <= rx_i.data_byte;
      s1_last_q <= rx_i.last_byte;
    end
    if (s1_adv && s1_last_q) begin
      status_q <= status_d;
      beacon_q <= beacon_d;
      len_q    <= len_d;
    end
  end

  assign st_o.valid           = out_valid_q;
  assign st_o.frame_status    = status_q;
  assign st_o.is_beacon       = beacon_q;
  assign st_o.frame_length    = len_q;
  assign st_o.frames_received = rcv_q;
  assign st_o.frames_bad      = bad_q;

`ifndef SYNTHESIS
  a_beacon_only_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_o.valid && st_o.is_beacon |-> st_o.frame_status == FS_ACCEPTED)
    else $error("beacon flag on a dropped frame");

  a_bad_implies_rcv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bad_q != $past(bad_q) |-> rcv_q != $past(rcv_q))
    else $error("bad counter moved without received counter");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntMax)
    else $error("byte count beyond maximum frame size");

  a_last_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_last_q && !out_free |=> s1_valid_q && s1_last_q)
    else $error("last byte lost while status output stalled");
`endif

endmodule

>>> test/fcs_status_checker.sv
module fcs_status_checker
  import fcs_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  fcs_rx_if               rx_i,
  fcs_st_if               st_i,
  input  logic            cfg_we_i,
  input  logic [LenW-1:0] cfg_wdata_i,
  output int              fail_count_o,
  output logic            drained_o
);

  typedef struct packed {
    frame_status_e     status;
    logic              beacon;
    logic [LenW-1:0]   len;
    logic [CountW-1:0] rcvd;
    logic [CountW-1:0] bad;
  } frame_result_t;

  frame_result_t     pending_status[$];
  logic [15:0]       crc_acc;
  logic [LenW-1:0]   byte_cnt;
  logic [1:0]        first_type;
  logic [CountW-1:0] rcvd_total;
  logic [CountW-1:0] bad_total;
  logic [LenW-1:0]   min_len;
  int                word_idx;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("status word %0d: %s got %0d expected %0d", word_idx, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t want;
    frame_result_t seen;
    logic [15:0]   crc_next;
    logic          fb;
    if (!rst_ni) begin
      crc_acc      = '0;
      byte_cnt     = '0;
      first_type   = '0;
      rcvd_total   = '0;
      bad_total    = '0;
      min_len      = MinLenReset;
      word_idx     = 0;
      fail_count_o = 0;
      pending_status.delete();
      drained_o <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        min_len = cfg_wdata_i;
      end

      if (st_i.valid && st_i.ready) begin
        if (pending_status.size() == 0) begin
          report_mismatch("word with none expected, status", st_i.frame_status, 0);
        end else begin
          want = pending_status.pop_front();
          seen = '{st_i.frame_status, st_i.is_beacon, st_i.frame_length,
                   st_i.frames_received, st_i.frames_bad};
          if (seen.status !== want.status) begin
            report_mismatch("frame_status", seen.status, want.status);
          end
          if (seen.beacon !== want.beacon) begin
            report_mismatch("is_beacon", seen.beacon, want.beacon);
          end
          if (seen.len !== want.len) begin
            report_mismatch("frame_length", seen.len, want.len);
          end
          if (seen.rcvd !== want.rcvd) begin
            report_mismatch("frames_received", seen.rcvd, want.rcvd);
          end
          if (seen.bad !== want.bad) begin
            report_mismatch("frames_bad", seen.bad, want.bad);
          end
        end
        word_idx++;
      end

      if (rx_i.valid && rx_i.ready) begin
        if (byte_cnt == 0) begin
          first_type = rx_i.data_byte[1:0];
        end
        // lsb first, the crc runs on past the saturated count
        crc_next = crc_acc;
        for (int k = 0; k < 8; k++) begin
          fb       = crc_next[0] ^ rx_i.data_byte[k];
          crc_next = crc_next >> 1;
          if (fb) begin
            crc_next = crc_next ^ CrcPolyRefl;
          end
        end
        crc_acc = crc_next;
        if (byte_cnt < MaxFrameBytesDef) begin
          byte_cnt = byte_cnt + 1'b1;
        end
        if (rx_i.last_byte) begin
          want.beacon = 1'b0;
          want.len    = byte_cnt;
          if (byte_cnt < min_len) begin
            want.status = FS_TOO_SHORT;
          end else begin
            rcvd_total++;
            if (crc_acc != '0) begin
              bad_total++;
              want.status = FS_CRC_ERROR;
            end else begin
              want.status = FS_ACCEPTED;
              want.beacon = (first_type == '0);
            end
          end
          want.rcvd = rcvd_total;
          want.bad  = bad_total;
          pending_status.push_back(want);
          crc_acc  = '0;
          byte_cnt = '0;
        end
      end

      drained_o <= (pending_status.size() == 0);
    end
  end

endmodule

>>> test/tb_frame_fcs_checker.sv
module tb_frame_fcs_checker;
  import fcs_pkg::*;

  localparam int LongHold = 300;

  typedef enum int {
    FK_GOOD,
    FK_CORRUPT,
    FK_RANDOM
  } frame_kind_e;

  logic            clk;
  logic            rst_n;
  logic            cfg_we;
  logic [LenW-1:0] cfg_wdata;
  int              fail_count;
  logic            drained;

  logic [7:0]      frame_q[$];
  logic [LenW-1:0] cur_min;
  int              bytes_sent;
  int              tx_calm;
  int              sink_calm;

  fcs_rx_if rx_if ();
  fcs_st_if st_if ();

  frame_fcs_checker dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .rx_i       (rx_if),
    .st_o       (st_if),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  fcs_status_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .rx_i        (rx_if),
    .st_i        (st_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .fail_count_o(fail_count),
    .drained_o   (drained)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // mostly short gaps, a few long ones, and calm stretches with none at all
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      calm = $urandom_range(10, 50);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // reflected crc appended low byte first, so the residue over the frame is zero
  function automatic void append_fcs();
    logic [15:0] crc;
    crc = '0;
    foreach (frame_q[i]) begin
      crc = crc ^ {8'h00, frame_q[i]};
      repeat (8) crc = crc[0] ? ((crc >> 1) ^ CrcPolyRefl) : (crc >> 1);
    end
    frame_q.push_back(crc[7:0]);
    frame_q.push_back(crc[15:8]);
  endfunction

  function automatic void build_frame(input int len, input frame_kind_e kind);
    logic [7:0] b;
    int         pos;
    frame_q.delete();
    for (int i = 0; i < len - 2; i++) begin
      b = 8'($urandom_range(0, 255));
      if (i == 0 && $urandom_range(0, 1)) begin
        b[1:0] = 2'b00;
      end
      frame_q.push_back(b);
    end
    if (kind == FK_RANDOM || len < 2) begin
      while (frame_q.size() < len) frame_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      append_fcs();
      if (kind == FK_CORRUPT) begin
        pos = $urandom_range(0, len - 1);
        frame_q[pos] = frame_q[pos] ^ (8'h01 << $urandom_range(0, 7));
      end
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_if.valid     <= 1'b1;
    rx_if.data_byte <= b;
    rx_if.last_byte <= l;
    do @(posedge clk); while (!rx_if.ready);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  task automatic wait_drained();
    rx_if.valid <= 1'b0;
    do @(posedge clk); while (!drained);
    // stay idle before the register write
    repeat (4) @(posedge clk);
  endtask

  task automatic set_min_len(input logic [LenW-1:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we  <= 1'b0;
    cur_min = v;
  endtask

  task automatic run_random(input int byte_goal, input int long_pct);
    int          start;
    int          len;
    int          r;
    frame_kind_e kind;
    start = bytes_sent;
    while (bytes_sent - start < byte_goal) begin
      r = $urandom_range(0, 99);
      if (r < long_pct) begin
        len = $urandom_range(128, 150);
      end else if (r < long_pct + 20) begin
        len = $urandom_range(1, 12);
      end else begin
        // lengths around the minimum
        len = (cur_min > 3) ? cur_min - 3 : 1;
        len = $urandom_range(len, len + 8);
      end
      r = $urandom_range(0, 99);
      if (r < 65) begin
        kind = FK_GOOD;
      end else if (r < 82) begin
        kind = FK_CORRUPT;
      end else begin
        kind = FK_RANDOM;
      end
      build_frame(len, kind);
      send_frame();
    end
  endtask

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // status side: random stalls plus a long hold-off now and then
  initial begin
    int gap;
    int seen;
    int hold_at;
    st_if.ready = 1'b0;
    seen        = 0;
    hold_at     = 30;
    sink_calm   = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (seen >= hold_at) begin
        hold_at = seen + 37;
        st_if.ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end
      gap = pick_gap(sink_calm);
      if (gap > 0) begin
        st_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      st_if.ready <= 1'b1;
      @(posedge clk);
      if (st_if.valid) seen++;
    end
  end

  initial begin
    rx_if.valid     = 1'b0;
    rx_if.data_byte = '0;
    rx_if.last_byte = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    rst_n           = 1'b0;
    cur_min         = MinLenReset;
    bytes_sent      = 0;
    tx_calm         = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_random(200, 2);

    set_min_len(7'd2);
    // single byte below the minimum
    frame_q = {8'h00};
    send_frame();
    // all-zero frame: zero residue, beacon
    frame_q.delete();
    append_fcs();
    send_frame();
    frame_q = {8'hFF};
    append_fcs();
    send_frame();
    frame_q = {8'h81, 8'h7E};
    append_fcs();
    frame_q[1] = frame_q[1] ^ 8'h10;
    send_frame();
    frame_q = {8'h02, 8'h80, 8'h55};
    append_fcs();
    send_frame();
    frame_q = {8'hAA};
    send_frame();

    // zero minimum: any single byte passes the length check
    set_min_len(7'd0);
    frame_q = {8'h00};
    send_frame();
    frame_q = {8'hFF};
    send_frame();
    frame_q = {8'h01};
    send_frame();
    run_random(100, 2);

    // only frames that reach the saturated count pass the length check
    set_min_len(7'd127);
    run_random(260, 15);

    set_min_len(LenW'($urandom_range(3, 24)));
    run_random(160, 2);

    set_min_len(7'd1);
    run_random(100, 2);

    wait_drained();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/fcs_pkg.sv
rtl/fcs_rx_if.sv
rtl/fcs_st_if.sv
rtl/frame_fcs_checker.sv
test/fcs_status_checker.sv
test/tb_frame_fcs_checker.sv
